// ===== rtl/core/lwfc_pkg.sv =====
package lwfc_pkg;

	// Beat layout on the stream ports
	localparam int CHAR_W     = 8;
	localparam int IDX_IN_W   = 6;
	localparam int POS_IN_W   = 5;
	localparam int S_TDATA_W  = 24;

	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 6;
	localparam int CNT_OUT_W  = 16;
	localparam int LEN_OUT_W  = 6;
	localparam int USED_OUT_W = 7;
	localparam int M_TDATA_W  = 48;
	localparam int M_PAD_W    = M_TDATA_W - (SLOT_W + CNT_OUT_W + LEN_OUT_W + CHAR_W + USED_OUT_W);

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7A;

	typedef enum logic [STATUS_W-1:0] {
		ST_CHAR   = 3'd0,
		ST_BAD    = 3'd1,
		ST_HIT    = 3'd2,
		ST_INSERT = 3'd3,
		ST_FULL   = 3'd4,
		ST_LONG   = 3'd5,
		ST_READ   = 3'd6,
		ST_EMPTY  = 3'd7
	} status_t;

	typedef struct packed {
		status_t                 status;
		logic [SLOT_W-1:0]       slot;
		logic [CNT_OUT_W-1:0]    count;
		logic [LEN_OUT_W-1:0]    len;
		logic [CHAR_W-1:0]       chr;
		logic [USED_OUT_W-1:0]   used;
	} res_t;

endpackage

// ===== rtl/core/lwfc_ram.sv =====
module lwfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next enabled read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/lowercase_word_frequency_counter.sv =====
// Character beat: result goes to the output register, or to the pending slot if stalled.
// Read beat: table read, then result; an unused entry is answered without a table read.
// End of word: each stored entry gets a length probe (S_PROBE, S_LENCHK), then
// a character compare (S_CMP) on equal length; an insert copies the word char by char.
// Throughput: one beat at a time, set by the single compare sequencer and the table RAM port.
// Reset (arst_n low): control, word collector and fill count clear; tables are empty at once.
module lowercase_word_frequency_counter #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_WORD_LEN  = 32,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// char_code [7:0], entry_index [13:8], char_pos [18:14], zero [23:19]
	input  logic [lwfc_pkg::S_TDATA_W-1:0] s_tdata,
	// func [0]
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// entry_slot [5:0], word_count [21:6], word_length [27:22], char_out [35:28],
	// entries_used [42:36], zero [47:43]
	output logic [lwfc_pkg::M_TDATA_W-1:0] m_tdata,
	// status [2:0]
	output logic [lwfc_pkg::STATUS_W-1:0]  m_tuser
);

	import lwfc_pkg::*;

	localparam int ENT_W   = $clog2(TABLE_ENTRIES);
	localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int POS_W   = $clog2(MAX_WORD_LEN);
	localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
	localparam int META_W  = LEN_W + COUNT_WIDTH;
	localparam int CHR_AW  = ENT_W + POS_W;
	localparam int CHR_DEPTH = 1 << CHR_AW;
	localparam int IDXW    = (USED_W > IDX_IN_W) ? USED_W : IDX_IN_W;
	localparam int PW      = (LEN_W > POS_IN_W) ? LEN_W : POS_IN_W;

	// One-hot sequencer states
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_READ   = 7'b0000010,
		S_PROBE  = 7'b0000100,
		S_LENCHK = 7'b0001000,
		S_CMP    = 7'b0010000,
		S_COPY   = 7'b0100000,
		S_WRITE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Word collector
	logic [LEN_W-1:0]  word_len_q, word_len_d;
	logic              bad_q, bad_d;
	logic              over_q, over_d;

	// Search / copy sequencer
	logic [LEN_W-1:0]  wlen_q, wlen_d;
	logic [USED_W-1:0] ent_q, ent_d;
	logic [LEN_W-1:0]  pos_q, pos_d;
	logic [USED_W-1:0] used_q, used_d;
	logic [IDX_IN_W-1:0] rd_idx_q, rd_idx_d;
	logic [POS_IN_W-1:0] rd_pos_q, rd_pos_d;

	// Result path: one pending slot ahead of the output register
	res_t res, pend_q, out_q;
	logic res_v, pend_v_q, out_v_q, out_free;

	// RAM ports
	logic              buf_we, buf_re;
	logic [POS_W-1:0]  buf_waddr, buf_raddr;
	logic [CHAR_W-1:0] buf_wdata, buf_rdata;
	logic              chr_we, chr_re;
	logic [CHR_AW-1:0] chr_waddr, chr_raddr;
	logic [CHAR_W-1:0] chr_wdata, chr_rdata;
	logic              meta_we, meta_re;
	logic [ENT_W-1:0]  meta_waddr, meta_raddr;
	logic [META_W-1:0] meta_wdata, meta_rdata;

	// Beat fields
	logic                accept;
	logic [CHAR_W-1:0]   char_code;
	logic [IDX_IN_W-1:0] entry_index;
	logic [POS_IN_W-1:0] char_pos;
	logic [ENT_W-1:0]    idx_ent;

	logic              lower, room, bad_n, over_n;
	logic [LEN_W-1:0]  len_n, pos_inc;
	logic [LEN_W-1:0]  meta_len;
	logic [COUNT_WIDTH-1:0] meta_cnt, cnt_sat;

	assign char_code   = s_tdata[7:0];
	assign entry_index = s_tdata[13:8];
	assign char_pos    = s_tdata[18:14];
	assign idx_ent     = ENT_W'(entry_index);

	assign s_tready = (state_q == S_IDLE) && !pend_v_q;
	assign accept   = s_tvalid && s_tready;

	assign lower  = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
	assign room   = word_len_q < LEN_W'(MAX_WORD_LEN);
	assign bad_n  = bad_q || !lower;
	assign over_n = over_q || !room;
	assign len_n  = room ? word_len_q + LEN_W'(1) : word_len_q;

	assign pos_inc  = pos_q + LEN_W'(1);
	assign meta_len = meta_rdata[META_W-1:COUNT_WIDTH];
	assign meta_cnt = meta_rdata[COUNT_WIDTH-1:0];
	// saturate at the all-ones count
	assign cnt_sat  = (&meta_cnt) ? meta_cnt : meta_cnt + COUNT_WIDTH'(1);

	always_comb begin
		state_d    = state_q;
		word_len_d = word_len_q;
		bad_d      = bad_q;
		over_d     = over_q;
		wlen_d     = wlen_q;
		ent_d      = ent_q;
		pos_d      = pos_q;
		used_d     = used_q;
		rd_idx_d   = rd_idx_q;
		rd_pos_d   = rd_pos_q;

		buf_we     = 1'b0;
		buf_waddr  = word_len_q[POS_W-1:0];
		buf_wdata  = char_code;
		buf_re     = 1'b0;
		buf_raddr  = pos_q[POS_W-1:0];
		chr_we     = 1'b0;
		chr_waddr  = {used_q[ENT_W-1:0], pos_q[POS_W-1:0]};
		chr_wdata  = buf_rdata;
		chr_re     = 1'b0;
		chr_raddr  = {ent_q[ENT_W-1:0], pos_q[POS_W-1:0]};
		meta_we    = 1'b0;
		meta_waddr = ent_q[ENT_W-1:0];
		meta_wdata = {meta_len, cnt_sat};
		meta_re    = 1'b0;
		meta_raddr = ent_q[ENT_W-1:0];

		res_v       = 1'b0;
		res         = '0;
		res.status  = ST_CHAR;
		res.used    = USED_OUT_W'(used_q);

		case (state_q)
			S_IDLE: begin
				if (accept && s_tuser) begin
					if (IDXW'(entry_index) >= IDXW'(used_q)) begin
						// unused entry: answer at once, echo the index
						res_v      = 1'b1;
						res.status = ST_EMPTY;
						res.slot   = SLOT_W'(entry_index);
					end else begin
						meta_re    = 1'b1;
						meta_raddr = idx_ent;
						chr_re     = 1'b1;
						chr_raddr  = {idx_ent, POS_W'(char_pos)};
						rd_idx_d   = entry_index;
						rd_pos_d   = char_pos;
						state_d    = S_READ;
					end
				end else if (accept) begin
					// collect the character; drop it past the length limit
					buf_we     = room;
					bad_d      = bad_n;
					over_d     = over_n;
					word_len_d = len_n;
					res_v      = !s_tlast;
					if (s_tlast) begin
						word_len_d = '0;
						bad_d      = 1'b0;
						over_d     = 1'b0;
						if (bad_n) begin
							res_v      = 1'b1;
							res.status = ST_BAD;
						end else if (over_n) begin
							res_v      = 1'b1;
							res.status = ST_LONG;
						end else begin
							wlen_d  = len_n;
							ent_d   = '0;
							state_d = S_PROBE;
						end
					end
				end
			end
			S_READ: begin
				res_v      = 1'b1;
				res.status = ST_READ;
				res.slot   = SLOT_W'(rd_idx_q);
				res.count  = CNT_OUT_W'(meta_cnt);
				res.len    = LEN_OUT_W'(meta_len);
				res.chr    = (PW'(rd_pos_q) < PW'(meta_len)) ? chr_rdata : '0;
				state_d    = S_IDLE;
			end
			S_PROBE: begin
				if (ent_q == used_q) begin
					if (used_q == USED_W'(TABLE_ENTRIES)) begin
						res_v      = 1'b1;
						res.status = ST_FULL;
						state_d    = S_IDLE;
					end else begin
						pos_d   = '0;
						state_d = S_COPY;
					end
				end else begin
					meta_re = 1'b1;
					pos_d   = '0;
					state_d = S_LENCHK;
				end
			end
			S_LENCHK: begin
				if (meta_len != wlen_q) begin
					ent_d   = ent_q + USED_W'(1);
					state_d = S_PROBE;
				end else begin
					buf_re  = 1'b1;
					chr_re  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (buf_rdata != chr_rdata) begin
					ent_d   = ent_q + USED_W'(1);
					state_d = S_PROBE;
				end else if (pos_inc == wlen_q) begin
					meta_we    = 1'b1;
					res_v      = 1'b1;
					res.status = ST_HIT;
					res.slot   = SLOT_W'(ent_q);
					res.count  = CNT_OUT_W'(cnt_sat);
					res.len    = LEN_OUT_W'(meta_len);
					state_d    = S_IDLE;
				end else begin
					// fetch the next character pair while comparing this one
					pos_d     = pos_inc;
					buf_re    = 1'b1;
					buf_raddr = pos_inc[POS_W-1:0];
					chr_re    = 1'b1;
					chr_raddr = {ent_q[ENT_W-1:0], pos_inc[POS_W-1:0]};
				end
			end
			S_COPY: begin
				buf_re  = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				chr_we = 1'b1;
				if (pos_inc == wlen_q) begin
					meta_we    = 1'b1;
					meta_waddr = used_q[ENT_W-1:0];
					meta_wdata = {wlen_q, COUNT_WIDTH'(1)};
					used_d     = used_q + USED_W'(1);
					res_v      = 1'b1;
					res.status = ST_INSERT;
					res.slot   = SLOT_W'(used_q);
					res.count  = CNT_OUT_W'(1);
					res.len    = LEN_OUT_W'(wlen_q);
					res.used   = USED_OUT_W'(used_d);
					state_d    = S_IDLE;
				end else begin
					pos_d   = pos_inc;
					state_d = S_COPY;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			word_len_q <= '0;
			bad_q      <= 1'b0;
			over_q     <= 1'b0;
			used_q     <= '0;
			ent_q      <= '0;
			pos_q      <= '0;
			wlen_q     <= '0;
		end else begin
			state_q    <= state_d;
			word_len_q <= word_len_d;
			bad_q      <= bad_d;
			over_q     <= over_d;
			used_q     <= used_d;
			ent_q      <= ent_d;
			pos_q      <= pos_d;
			wlen_q     <= wlen_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_idx_d;
		rd_pos_q <= rd_pos_d;
	end

	// Output register with one pending slot ahead of it, so a new beat can be
	// taken while a finished result still waits on m_tready.
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= res_v;
			end else begin
				out_v_q  <= res_v;
			end
		end else if (res_v) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
				if (res_v) begin
					pend_q <= res;
				end
			end else if (res_v) begin
				out_q <= res;
			end
		end else if (res_v) begin
			pend_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_q.used, out_q.chr, out_q.len,
		out_q.count, out_q.slot};

	// Word buffer, character table, length/count table
	lwfc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_WORD_LEN)
	) u_word_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	lwfc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CHR_DEPTH)
	) u_chars (
		.clk   (clk),
		.we    (chr_we),
		.waddr (chr_waddr),
		.wdata (chr_wdata),
		.re    (chr_re),
		.raddr (chr_raddr),
		.rdata (chr_rdata)
	);

	lwfc_ram #(
		.WIDTH(META_W),
		.DEPTH(TABLE_ENTRIES)
	) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	// A result is never made while the pending slot is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |-> !pend_v_q)
		else $error("result produced with pending slot occupied");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_cmp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (pos_q < wlen_q))
		else $error("compare position past word length");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && pos_inc == wlen_q) |=>
		(used_q == $past(used_q) + USED_W'(1)))
		else $error("insert did not advance fill count");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_len_q <= LEN_W'(MAX_WORD_LEN))
		else $error("word collector past length limit");

endmodule

// ===== test/lowercase_word_frequency_counter_test.sv =====
`timescale 1ns / 100ps

module lowercase_word_frequency_counter_test;

	import lwfc_pkg::*;

	localparam int TABLE_SIZE = 64;
	localparam int WORD_MAX   = 32;
	localparam int CNT_BITS   = 16;
	localparam logic [CNT_BITS-1:0] COUNT_CEILING = '1;

	// Slowest legal beat: a scan of every stored entry with full-length compares plus an
	// insert copy, with random gaps on both sides. Budget several times that cost
	// over every beat of the run.
	localparam int unsigned CYCLE_LIMIT  = 10_000_000;
	localparam int unsigned SETTLE_WAIT  = 2500;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int          RANDOM_BEATS = 850;

	typedef struct {
		bit              func;
		logic [7:0]      code;
		bit              last;
		logic [5:0]      idx;
		logic [4:0]      pos;
		int unsigned     gap;
	} beat_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	lowercase_word_frequency_counter #(
		.TABLE_ENTRIES (TABLE_SIZE),
		.MAX_WORD_LEN  (WORD_MAX),
		.COUNT_WIDTH   (CNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	beat_t       beats_to_send[$];
	res_t        predicted_outcomes[$];
	beat_t       beat_on_bus;
	int unsigned gap_count;
	int unsigned beats_accepted;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned status_seen[8];
	bit          tx_idle;
	bit          rx_idle;
	bit          hold_armed;
	bit          hold_done;
	int unsigned rx_wait;
	int unsigned rx_stall_left;

	// Shadow of the counter: word being collected and the table of distinct words
	logic [7:0]          pend_chars[WORD_MAX];
	int unsigned         pend_len;
	bit                  pend_invalid;
	bit                  pend_overflow;
	logic [7:0]          stored_chars[TABLE_SIZE][WORD_MAX];
	logic [5:0]          stored_len[TABLE_SIZE];
	logic [CNT_BITS-1:0] stored_count[TABLE_SIZE];
	int unsigned         stored_total;

	function automatic res_t tally_beat(beat_t b);
		res_t r;
		int   found;
		bit   same;
		r = '0;
		r.status = ST_CHAR;
		if (b.func) begin
			r.slot = b.idx;
			if (b.idx >= stored_total) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_READ;
				r.count = stored_count[b.idx];
				r.len = stored_len[b.idx];
				if (b.pos < stored_len[b.idx])
					r.chr = stored_chars[b.idx][b.pos];
			end
			r.used = USED_OUT_W'(stored_total);
			return r;
		end
		if (b.code < CHAR_A || b.code > CHAR_Z)
			pend_invalid = 1'b1;
		if (pend_len < WORD_MAX) begin
			pend_chars[pend_len] = b.code;
			pend_len++;
		end else begin
			pend_overflow = 1'b1;
		end
		if (!b.last) begin
			r.used = USED_OUT_W'(stored_total);
			return r;
		end
		// Invalid characters win over overflow
		if (pend_invalid) begin
			r.status = ST_BAD;
		end else if (pend_overflow) begin
			r.status = ST_LONG;
		end else begin
			found = -1;
			for (int e = 0; e < stored_total; e++) begin
				if (found < 0 && stored_len[e] == pend_len) begin
					same = 1'b1;
					for (int k = 0; k < pend_len; k++)
						if (stored_chars[e][k] != pend_chars[k])
							same = 1'b0;
					if (same)
						found = e;
				end
			end
			if (found >= 0) begin
				if (stored_count[found] != COUNT_CEILING)
					stored_count[found]++;
				r.status = ST_HIT;
				r.slot = SLOT_W'(found);
				r.count = stored_count[found];
				r.len = stored_len[found];
			end else if (stored_total >= TABLE_SIZE) begin
				r.status = ST_FULL;
			end else begin
				for (int k = 0; k < pend_len; k++)
					stored_chars[stored_total][k] = pend_chars[k];
				stored_len[stored_total] = 6'(pend_len);
				stored_count[stored_total] = CNT_BITS'(1);
				r.status = ST_INSERT;
				r.slot = SLOT_W'(stored_total);
				r.count = CNT_OUT_W'(1);
				r.len = LEN_OUT_W'(pend_len);
				stored_total++;
			end
		end
		// Restart the collector whatever the outcome
		pend_len = 0;
		pend_invalid = 1'b0;
		pend_overflow = 1'b0;
		r.used = USED_OUT_W'(stored_total);
		return r;
	endfunction

	task automatic report_fault(string msg);
		$display("MISMATCH at result %0d: %s", results_checked, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_fault($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Driver: hold each beat until accepted, then wait its gap before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			gap_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_outcomes.push_back(tally_beat(beat_on_bus));
				beats_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (beats_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (gap_count < beats_to_send[0].gap) begin
					gap_count <= gap_count + 1;
					s_tvalid <= 1'b0;
				end else begin
					beat_on_bus = beats_to_send.pop_front();
					s_tdata <= {5'b0, beat_on_bus.pos, beat_on_bus.idx, beat_on_bus.code};
					s_tuser <= beat_on_bus.func;
					s_tlast <= beat_on_bus.last;
					s_tvalid <= 1'b1;
					gap_count <= 0;
				end
			end
		end
	end

	// Monitor: check each result beat, then draw the stall before the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall_left <= 0;
		end else begin
			rx_wait = rx_stall_left;
			if (m_tvalid && m_tready) begin
				if (predicted_outcomes.size() == 0) begin
					report_fault($sformatf("unexpected beat status %0d data 0x%0h",
						m_tuser, m_tdata));
				end else begin
					res_t want;
					want = predicted_outcomes.pop_front();
					compare_field("status", 32'(m_tuser), 32'(want.status));
					compare_field("entry_slot", 32'(m_tdata[5:0]), 32'(want.slot));
					compare_field("word_count", 32'(m_tdata[21:6]), 32'(want.count));
					compare_field("word_length", 32'(m_tdata[27:22]), 32'(want.len));
					compare_field("char_out", 32'(m_tdata[35:28]), 32'(want.chr));
					compare_field("entries_used", 32'(m_tdata[42:36]), 32'(want.used));
					compare_field("pad", 32'(m_tdata[47:43]), 32'd0);
				end
				status_seen[m_tuser]++;
				results_checked++;
				if ($urandom_range(0, 29) == 0)
					rx_idle = !rx_idle;
				rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
				// One long back-pressure stretch so the block fills and stalls its input
				if (hold_armed && !hold_done && results_checked % 97 == 0) begin
					rx_wait = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (rx_wait != 0) begin
				m_tready <= 1'b0;
				rx_stall_left <= rx_wait - 1;
			end else begin
				m_tready <= 1'b1;
				rx_stall_left <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				predicted_outcomes.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic queue_beat(bit func, logic [7:0] code, bit last, logic [5:0] idx,
		logic [4:0] pos);
		beat_t b;
		b.func = func;
		b.code = code;
		b.last = last;
		b.idx = idx;
		b.pos = pos;
		b.gap = tx_idle ? $urandom_range(0, 19) : 0;
		beats_to_send.push_back(b);
	endtask

	// Character beats carry random junk in the read fields, and reads in the char fields
	task automatic queue_char(logic [7:0] code, bit last);
		queue_beat(1'b0, code, last, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
	endtask

	task automatic queue_read(logic [5:0] idx, logic [4:0] pos);
		queue_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx, pos);
	endtask

	task automatic queue_word(string w, bit interleave);
		for (int i = 0; i < w.len(); i++) begin
			if (interleave && $urandom_range(0, 9) == 0)
				queue_read(6'($urandom_range(0, 15)), 5'($urandom_range(0, 3)));
			queue_char(w[i], i == w.len() - 1);
		end
	endtask

	function automatic string lower_word(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = $sformatf("%s%c", s, $urandom_range(CHAR_A, CHAR_Z));
		return s;
	endfunction

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (beats_to_send.size() != 0 || s_tvalid || predicted_outcomes.size() != 0);
	endtask

	initial begin
		string       w;
		string       known[$];
		int          pick;
		int          n;
		int unsigned waited;
		int unsigned goal;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reads, first inserts, invalid boundaries, read mid-word
		tx_idle = 1'b1;
		queue_read(6'd0, 5'd0);
		queue_read(6'd63, 5'd31);
		queue_word("a", 1'b0);
		queue_word("zz", 1'b0);
		queue_char(8'h00, 1'b0);
		queue_char(CHAR_A, 1'b1);
		queue_char(8'hFF, 1'b1);
		queue_char(CHAR_A - 8'd1, 1'b0);
		queue_char(CHAR_Z + 8'd1, 1'b1);
		queue_char(CHAR_A, 1'b0);
		queue_read(6'd1, 5'd1);
		queue_char(CHAR_A + 8'd1, 1'b1);
		queue_word("zz", 1'b0);
		queue_read(6'd1, 5'd2);
		queue_read(6'd2, 5'd1);
		queue_read(6'd3, 5'd0);
		queue_read(6'd0, 5'd0);
		wait_quiet();

		// Random: mostly clean words with repeats, some noise, reads and long words
		hold_armed = 1'b1;
		tx_idle = 1'b1;
		goal = beats_accepted + RANDOM_BEATS;
		w = lower_word(WORD_MAX);
		known.push_back(w);
		queue_word(w, 1'b0);
		queue_read(6'd3, 5'd31);
		queue_word(lower_word(WORD_MAX + 1), 1'b0);
		w = lower_word(WORD_MAX + 2);
		w.putc(WORD_MAX + 1, CHAR_Z + 8'd1);
		queue_word(w, 1'b0);
		queue_word("zz", 1'b1);
		while (beats_accepted + beats_to_send.size() < goal) begin
			if ($urandom_range(0, 49) == 0)
				tx_idle = !tx_idle;
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				w = lower_word($urandom_range(1, 5));
				known.push_back(w);
				queue_word(w, 1'b1);
			end else if (pick < 70) begin
				queue_word(known[$urandom_range(0, known.size() - 1)], 1'b1);
			end else if (pick < 82) begin
				queue_read(6'($urandom_range(0, 1) ? $urandom_range(0, 63) :
					$urandom_range(0, 7)),
					5'($urandom_range(0, 1) ? $urandom_range(0, 31) :
					$urandom_range(0, 3)));
			end else if (pick < 90) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					queue_char(8'($urandom_range(0, 255)), k == n - 1);
			end else if (pick < 99) begin
				// Near misses: prefix or extension of a known word
				w = known[$urandom_range(0, known.size() - 1)];
				if (w.len() > 1 && $urandom_range(0, 1))
					w = w.substr(0, w.len() - 2);
				else if (w.len() < WORD_MAX)
					w = {w, "q"};
				queue_word(w, 1'b0);
			end else begin
				queue_word(lower_word($urandom_range(WORD_MAX + 1, WORD_MAX + 4)), 1'b0);
			end
		end

		while (beats_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		waited = 0;
		while (predicted_outcomes.size() != 0 && waited < 20 * SETTLE_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_WAIT) @(posedge clk);
		if (predicted_outcomes.size() != 0)
			report_fault($sformatf("%0d expected results never arrived",
				predicted_outcomes.size()));

		$display("Checked %0d results from %0d beats; table holds %0d distinct words",
			results_checked, beats_accepted, stored_total);
		$display("  inserts %0d, hits %0d, invalid %0d, too long %0d, full %0d, reads %0d/%0d",
			status_seen[ST_INSERT], status_seen[ST_HIT], status_seen[ST_BAD],
			status_seen[ST_LONG], status_seen[ST_FULL], status_seen[ST_READ],
			status_seen[ST_EMPTY]);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lwfc_pkg.sv
rtl/core/lwfc_ram.sv
rtl/core/lowercase_word_frequency_counter.sv
test/lowercase_word_frequency_counter_test.sv
